@@ sv/yawpid_pkg.sv @@
// Shared types, constants and helpers for the yaw PID controller.
// No dependencies; imported by every module of the block.
package yawpid_pkg;

	localparam int HIST_DEPTH_DEF   = 10;
	localparam int COUNTS_PER_TURN  = 448;
	localparam int DEGREES_PER_TURN = 360;
	localparam int SUM_SCALE        = 1000;

	localparam int GAIN_W     = 10;
	localparam int DUTY_W     = 7;
	localparam int HEAD_W     = 9;
	localparam int ERR_W      = 9;
	localparam int TCNT_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int TDATA_W    = 24;
	localparam int PROD_W     = 21;
	localparam int INTEG_W    = 32;
	localparam int DIV_W      = 34;
	localparam int DIVR_W     = 10;
	localparam int QS_W       = 25;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOVER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DMAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DMIN  = 3'd6;

	localparam logic [GAIN_W-1:0] KP_RST    = 10'd150;
	localparam logic [GAIN_W-1:0] KI_RST    = 10'd70;
	localparam logic [GAIN_W-1:0] KD_RST    = 10'd300;
	localparam logic [GAIN_W-1:0] RATE_RST  = 10'd50;
	localparam logic [DUTY_W-1:0] HOVER_RST = 7'd30;
	localparam logic [DUTY_W-1:0] DMAX_RST  = 7'd70;
	localparam logic [DUTY_W-1:0] DMIN_RST  = 7'd2;

	// datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
	localparam logic [OP_W-1:0] OP_TCONV = 4'd2;
	localparam logic [OP_W-1:0] OP_ERR   = 4'd3;
	localparam logic [OP_W-1:0] OP_MULI  = 4'd4;
	localparam logic [OP_W-1:0] OP_DIVI  = 4'd5;
	localparam logic [OP_W-1:0] OP_ACCI  = 4'd6;
	localparam logic [OP_W-1:0] OP_DIVD  = 4'd7;
	localparam logic [OP_W-1:0] OP_DTERM = 4'd8;
	localparam logic [OP_W-1:0] OP_SUM   = 4'd9;
	localparam logic [OP_W-1:0] OP_DIVS  = 4'd10;
	localparam logic [OP_W-1:0] OP_QSUM  = 4'd11;
	localparam logic [OP_W-1:0] OP_OUT   = 4'd12;

	// step conditions: step holds until met
	localparam int C_W = 2;
	localparam logic [C_W-1:0] C_NONE = 2'd0;
	localparam logic [C_W-1:0] C_IN   = 2'd1;
	localparam logic [C_W-1:0] C_DIV  = 2'd2;
	localparam logic [C_W-1:0] C_OUT  = 2'd3;

	// program addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_LOAD  = 4'd0;
	localparam logic [STEP_W-1:0] ST_TCONV = 4'd1;
	localparam logic [STEP_W-1:0] ST_ERR   = 4'd2;
	localparam logic [STEP_W-1:0] ST_MULI  = 4'd3;
	localparam logic [STEP_W-1:0] ST_DIVI  = 4'd4;
	localparam logic [STEP_W-1:0] ST_ACCI  = 4'd5;
	localparam logic [STEP_W-1:0] ST_DIVD  = 4'd6;
	localparam logic [STEP_W-1:0] ST_DTERM = 4'd7;
	localparam logic [STEP_W-1:0] ST_SUM   = 4'd8;
	localparam logic [STEP_W-1:0] ST_DIVS  = 4'd9;
	localparam logic [STEP_W-1:0] ST_QSUM  = 4'd10;
	localparam logic [STEP_W-1:0] ST_OUT   = 4'd11;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [C_W-1:0]    cond;
		logic              jmp;
		logic [STEP_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [GAIN_W-1:0] rate;
		logic [DUTY_W-1:0] hover;
		logic [DUTY_W-1:0] dmax;
		logic [DUTY_W-1:0] dmin;
	} cfg_t;

	// degrees to counts: d*448/360 = d*56/45, by reciprocal
	localparam int TCONV_SHIFT = 21;
	localparam int TCONV_NUM   = COUNTS_PER_TURN / 8;
	localparam int TCONV_DEN   = DEGREES_PER_TURN / 8;
	localparam int TCONV_RECIP = ((1 << TCONV_SHIFT) + TCONV_DEN - 1) / TCONV_DEN;
	localparam int TCONV_PW    = 31;
	localparam logic [TCONV_PW-1:0] TCONV_MUL = TCONV_PW'(TCONV_NUM * TCONV_RECIP);

	function automatic logic [TCNT_W-1:0] deg_to_counts(input logic [HEAD_W-1:0] d);
		logic [TCONV_PW-1:0] p;
		p = TCONV_PW'(d) * TCONV_MUL;
		return p[TCONV_SHIFT +: TCNT_W];
	endfunction

endpackage

@@ sv/yawpid_ucode.sv @@
// Control store of the yaw PID sequencer: one control word per step.
// Depends on yawpid_pkg.
module yawpid_ucode (
	input  logic [yawpid_pkg::STEP_W-1:0] step,
	output yawpid_pkg::ucw_t              cw
);
	import yawpid_pkg::*;

	always_comb begin
		unique case (step)
			ST_LOAD:  cw = '{OP_LOAD,  C_IN,   1'b0, ST_LOAD};
			ST_TCONV: cw = '{OP_TCONV, C_NONE, 1'b0, ST_LOAD};
			ST_ERR:   cw = '{OP_ERR,   C_NONE, 1'b0, ST_LOAD};
			ST_MULI:  cw = '{OP_MULI,  C_NONE, 1'b0, ST_LOAD};
			ST_DIVI:  cw = '{OP_DIVI,  C_NONE, 1'b0, ST_LOAD};
			ST_ACCI:  cw = '{OP_ACCI,  C_DIV,  1'b0, ST_LOAD};
			ST_DIVD:  cw = '{OP_DIVD,  C_NONE, 1'b0, ST_LOAD};
			ST_DTERM: cw = '{OP_DTERM, C_DIV,  1'b0, ST_LOAD};
			ST_SUM:   cw = '{OP_SUM,   C_NONE, 1'b0, ST_LOAD};
			ST_DIVS:  cw = '{OP_DIVS,  C_NONE, 1'b0, ST_LOAD};
			ST_QSUM:  cw = '{OP_QSUM,  C_DIV,  1'b0, ST_LOAD};
			ST_OUT:   cw = '{OP_OUT,   C_OUT,  1'b1, ST_LOAD};
			default:  cw = '{OP_NOP,   C_NONE, 1'b1, ST_LOAD};
		endcase
	end

endmodule

@@ sv/yawpid_div.sv @@
// Signed by unsigned divider, two quotient bits per cycle, truncating.
// Depends on yawpid_pkg.
module yawpid_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [yawpid_pkg::DIV_W-1:0] num,
	input  logic [yawpid_pkg::DIVR_W-1:0]     den,
	output logic                              busy,
	output logic signed [yawpid_pkg::DIV_W-1:0] quot
);
	import yawpid_pkg::*;

	localparam int STEPS = DIV_W / 2;
	localparam int CNT_W = $clog2(STEPS + 2);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(STEPS + 1);
	localparam logic [CNT_W-1:0] CNT_FIX  = CNT_W'(1);

	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  work_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] den_q;
	logic              neg_q;
	logic signed [DIV_W-1:0] quot_q;

	logic [DIVR_W:0] r1, r1s, r2, r2s;
	logic            q1, q2;

	always_comb begin
		r1  = {rem_q, work_q[DIV_W-1]};
		q1  = r1 >= {1'b0, den_q};
		r1s = q1 ? r1 - {1'b0, den_q} : r1;
		r2  = {r1s[DIVR_W-1:0], work_q[DIV_W-2]};
		q2  = r2 >= {1'b0, den_q};
		r2s = q2 ? r2 - {1'b0, den_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_LOAD;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_FIX;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num[DIV_W-1] ? -num : num;
			rem_q  <= '0;
			den_q  <= den;
			neg_q  <= num[DIV_W-1];
		end else if (cnt_q > CNT_FIX) begin
			work_q <= {work_q[DIV_W-3:0], q1, q2};
			rem_q  <= r2s[DIVR_W-1:0];
		end else if (cnt_q == CNT_FIX) begin
			quot_q <= neg_q ? -$signed(work_q) : $signed(work_q);
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

@@ sv/yawpid_dp.sv @@
// Datapath of the yaw PID: wrap error, shared multiplier, divider,
// error history store and output register. Depends on yawpid_pkg, yawpid_div.
module yawpid_dp #(
	parameter int HISTORY_DEPTH = yawpid_pkg::HIST_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  yawpid_pkg::cfg_t                 cfg,
	input  logic [yawpid_pkg::OP_W-1:0]      op,
	output logic                             div_busy,
	input  logic [yawpid_pkg::TDATA_W-1:0]   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [yawpid_pkg::TDATA_W-1:0]   out_data
);
	import yawpid_pkg::*;

	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam int OUT_BITS = DUTY_W + ERR_W + 2;
	localparam logic [HEAD_W-1:0] TURN_H = HEAD_W'(COUNTS_PER_TURN);
	localparam logic [TCNT_W-1:0] TURN_T = TCNT_W'(COUNTS_PER_TURN);
	localparam logic signed [TCNT_W:0] TURN_S = (TCNT_W + 1)'(COUNTS_PER_TURN);
	localparam logic signed [ERR_W-1:0] ERR_SMALL = ERR_W'(2);
	localparam logic [GAIN_W-1:0] RATE_ONE = GAIN_W'(1);

	logic [HEAD_W-1:0]        head_q, tdeg_q;
	logic                     req_q, guard_q;
	logic [TCNT_W-1:0]        tcnt_q;
	logic signed [ERR_W-1:0]  err_q, past_raw_q, past;
	logic                     past_ok_q, cleared_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic signed [ERR_W-1:0]  hist_mem [HISTORY_DEPTH];
	logic signed [PROD_W-1:0] prod_q, dterm_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic signed [DIV_W-1:0]  acc_q;
	logic signed [QS_W-1:0]   qsum_q;
	logic                     out_valid_q;
	logic [DUTY_W-1:0]        duty_q;
	logic signed [ERR_W-1:0]  yerr_q;
	logic                     clamped_q, cleared_out_q;

	// wrap error
	logic [HEAD_W-1:0]        h_w;
	logic [TCNT_W-1:0]        t_w;
	logic signed [TCNT_W:0]   direct, around, ad, aa;
	logic signed [ERR_W-1:0]  err_w;
	logic                     clr_w;

	always_comb begin
		h_w    = (head_q >= TURN_H) ? head_q - TURN_H : head_q;
		t_w    = (tcnt_q >= TURN_T) ? tcnt_q - TURN_T : tcnt_q;
		direct = $signed({1'b0, t_w}) - $signed({2'b0, h_w});
		around = (t_w > TCNT_W'(h_w)) ? direct - TURN_S : direct + TURN_S;
		ad     = direct[TCNT_W] ? -direct : direct;
		aa     = around[TCNT_W] ? -around : around;
		err_w  = (ad <= aa) ? direct[ERR_W-1:0] : around[ERR_W-1:0];
		clr_w  = (err_w > -ERR_SMALL) && (err_w < ERR_SMALL) && req_q && guard_q;
	end

	// shared multiplier
	logic signed [ERR_W:0]    mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic signed [PROD_W-1:0] mul_p;

	assign past = past_ok_q ? past_raw_q : '0;

	always_comb begin
		unique case (op)
			OP_MULI: begin
				mul_a = (ERR_W + 1)'(err_q);
				mul_b = cfg.ki;
			end
			OP_ACCI: begin
				mul_a = (ERR_W + 1)'(err_q) - (ERR_W + 1)'(past);
				mul_b = cfg.kd;
			end
			default: begin
				mul_a = (ERR_W + 1)'(err_q);
				mul_b = cfg.kp;
			end
		endcase
		mul_p = mul_a * $signed({1'b0, mul_b});
	end

	// divider
	logic                     div_start;
	logic signed [DIV_W-1:0]  div_num, quot;
	logic [DIVR_W-1:0]        div_den, rate_eff;

	assign rate_eff  = (cfg.rate == '0) ? RATE_ONE : cfg.rate;
	assign div_start = (op == OP_DIVI) || (op == OP_DIVD) || (op == OP_DIVS);
	assign div_num   = (op == OP_DIVS) ? acc_q : DIV_W'(prod_q);
	assign div_den   = (op == OP_DIVS) ? DIVR_W'(SUM_SCALE) : rate_eff;

	yawpid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot)
	);

	// integral accumulate with saturation
	logic signed [DIV_W-1:0]   isum;
	logic                      sat_pos, sat_neg;
	logic signed [INTEG_W-1:0] isat;

	always_comb begin
		isum    = DIV_W'(integral_q) + quot;
		sat_pos = !isum[DIV_W-1] && (|isum[DIV_W-2:INTEG_W-1]);
		sat_neg = isum[DIV_W-1] && !(&isum[DIV_W-2:INTEG_W-1]);
		if (sat_pos)
			isat = {1'b0, {(INTEG_W - 1){1'b1}}};
		else if (sat_neg)
			isat = {1'b1, {(INTEG_W - 1){1'b0}}};
		else
			isat = isum[INTEG_W-1:0];
	end

	// duty and clamp
	logic signed [QS_W:0]     resp;
	logic [DUTY_W-1:0]        duty_w;
	logic                     clamp_w;

	always_comb begin
		resp = (QS_W + 1)'($signed({1'b0, cfg.hover})) + (QS_W + 1)'(qsum_q);
		if (resp > $signed({1'b0, cfg.dmax})) begin
			duty_w  = cfg.dmax;
			clamp_w = 1'b1;
		end else if (resp < $signed({1'b0, cfg.dmin})) begin
			duty_w  = cfg.dmin;
			clamp_w = 1'b1;
		end else begin
			duty_w  = resp[DUTY_W-1:0];
			clamp_w = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q     <= 1'b1;
			integral_q  <= '0;
			ptr_q       <= '0;
			hist_vld_q  <= '0;
			past_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_LOAD && in_data[HEAD_W + HEAD_W + 1])
				guard_q <= 1'b1;
			if (op == OP_TCONV)
				past_ok_q <= hist_vld_q[ptr_q];
			if (op == OP_ERR && clr_w) begin
				guard_q    <= 1'b0;
				integral_q <= '0;
			end
			if (op == OP_MULI) begin
				hist_vld_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_ONE;
			end
			if (op == OP_ACCI)
				integral_q <= isat;
			if (op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_TCONV)
			past_raw_q <= hist_mem[ptr_q];
		if (op == OP_MULI)
			hist_mem[ptr_q] <= err_q;
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				head_q <= in_data[HEAD_W-1:0];
				tdeg_q <= in_data[HEAD_W +: HEAD_W];
				req_q  <= in_data[HEAD_W + HEAD_W];
			end
			OP_TCONV: tcnt_q <= deg_to_counts(tdeg_q);
			OP_ERR: begin
				err_q     <= err_w;
				cleared_q <= clr_w;
			end
			OP_MULI:  prod_q <= mul_p;
			OP_ACCI:  prod_q <= mul_p;
			OP_DTERM: begin
				dterm_q <= quot[PROD_W-1:0];
				prod_q  <= mul_p;
			end
			OP_SUM:   acc_q  <= DIV_W'(prod_q) + DIV_W'(integral_q) + DIV_W'(dterm_q);
			OP_QSUM:  qsum_q <= quot[QS_W-1:0];
			OP_OUT: begin
				duty_q        <= duty_w;
				yerr_q        <= err_q;
				clamped_q     <= clamp_w;
				cleared_out_q <= cleared_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{(TDATA_W - OUT_BITS){1'b0}}, cleared_out_q, clamped_q, yerr_q, duty_q};

endmodule

@@ sv/yaw_pid_with_wrap.sv @@
// Yaw PID controller with wrap-around heading error, top level.
// Items are handled one at a time: a new input beat is taken only once the previous
// result is loaded for output, after three passes through the shared
// two-bit-per-cycle divider and the rest of the step sequence.
// Reset: registers to defaults, integral zero, history reads zero, guard armed.
// Depends on yawpid_pkg, yawpid_ucode, yawpid_dp.
module yaw_pid_with_wrap #(
	parameter int HISTORY_DEPTH = yawpid_pkg::HIST_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [yawpid_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [yawpid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// heading[8:0], target_degrees[17:9], integral_reset_request[18], rearm_guard[19]
	input  logic [yawpid_pkg::TDATA_W-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// duty[6:0], yaw_error[15:7], clamped[16], integral_cleared[17]
	output logic [yawpid_pkg::TDATA_W-1:0]       m_axis_tdata
);
	import yawpid_pkg::*;

	localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

	cfg_t              cfg_q;
	logic [STEP_W-1:0] step_q;
	ucw_t              cw;
	logic              go, div_busy;
	logic [OP_W-1:0]   op_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{KP_RST, KI_RST, KD_RST, RATE_RST, HOVER_RST, DMAX_RST, DMIN_RST};
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_KP:    cfg_q.kp    <= cfg_wdata;
				REG_KI:    cfg_q.ki    <= cfg_wdata;
				REG_KD:    cfg_q.kd    <= cfg_wdata;
				REG_RATE:  cfg_q.rate  <= cfg_wdata;
				REG_HOVER: cfg_q.hover <= cfg_wdata[DUTY_W-1:0];
				REG_DMAX:  cfg_q.dmax  <= cfg_wdata[DUTY_W-1:0];
				REG_DMIN:  cfg_q.dmin  <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	yawpid_ucode u_ucode (
		.step (step_q),
		.cw   (cw)
	);

	always_comb begin
		unique case (cw.cond)
			C_IN:    go = s_axis_tvalid;
			C_DIV:   go = !div_busy;
			C_OUT:   go = !m_axis_tvalid || m_axis_tready;
			default: go = 1'b1;
		endcase
	end

	assign op_x          = go ? cw.op : OP_NOP;
	assign s_axis_tready = cw.cond == C_IN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_LOAD;
		else if (go)
			step_q <= cw.jmp ? cw.target : step_q + STEP_ONE;
	end

	yawpid_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op        (op_x),
		.div_busy  (div_busy),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(op_x == OP_DIVI || op_x == OP_DIVD || op_x == OP_DIVS) |-> !div_busy)
		else $error("divider restarted while busy");

	a_beat_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> step_q == ST_TCONV)
		else $error("input beat did not advance the program");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(op_x == OP_OUT) |=> m_axis_tvalid)
		else $error("result not offered after output step");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ST_OUT)
		else $error("step counter outside program");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for yaw_pid_with_wrap: drives heading/target beats, predicts each
// result from an in-bench copy of the PID state and compares every output beat.
// Depends on yawpid_pkg and the yaw_pid_with_wrap RTL.
`timescale 1ns / 100ps

module tb;
	import yawpid_pkg::*;

	typedef struct packed {
		logic              rearm;
		logic              req;
		logic [HEAD_W-1:0] tdeg;
		logic [HEAD_W-1:0] heading;
	} yaw_cmd_t;

	typedef struct packed {
		logic              cleared;
		logic              clamped;
		logic [ERR_W-1:0]  yaw_err;
		logic [DUTY_W-1:0] duty;
	} yaw_res_t;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int     CMD_W       = $bits(yaw_cmd_t);
	localparam int     RES_W       = $bits(yaw_res_t);
	localparam longint INTEG_MAX   = 2147483647;
	localparam longint INTEG_MIN   = -INTEG_MAX - 1;
	localparam int     HOLD_CYCLES = 600;
	localparam int     SAT_ITEMS   = 9450;
	localparam int     TAIL_CYCLES = 130;
	localparam int     CYCLE_LIMIT = 4000000;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]    m_axis_tdata;

	// register shadow
	logic [GAIN_W-1:0] kp_q    = KP_RST;
	logic [GAIN_W-1:0] ki_q    = KI_RST;
	logic [GAIN_W-1:0] kd_q    = KD_RST;
	logic [GAIN_W-1:0] rate_q  = RATE_RST;
	logic [DUTY_W-1:0] hover_q = HOVER_RST;
	logic [DUTY_W-1:0] dmax_q  = DMAX_RST;
	logic [DUTY_W-1:0] dmin_q  = DMIN_RST;

	// controller state
	longint integ_acc   = 0;
	int     err_hist [HIST_DEPTH_DEF];
	int     hist_ptr    = 0;
	bit     guard_armed = 1'b1;

	yaw_cmd_t cmd_backlog [$];
	yaw_res_t due_results [$];
	yaw_res_t mon_got, mon_want;

	bit no_gaps    = 1'b0;
	bit hold_on    = 1'b0;
	bit hold_done  = 1'b0;
	int hold_count = 0;
	int mismatches = 0;
	int beats_seen = 0;
	int cycle_count = 0;
	bit sat_up;

	yaw_pid_with_wrap u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic yaw_res_t yaw_pid_step(yaw_cmd_t c);
		yaw_res_t r;
		int       h, t, direct, around, err;
		longint   rate, p, d, resp;
		h = int'(c.heading);
		if (h >= COUNTS_PER_TURN) h -= COUNTS_PER_TURN;
		t = int'(c.tdeg) * COUNTS_PER_TURN / DEGREES_PER_TURN;
		if (t >= COUNTS_PER_TURN) t -= COUNTS_PER_TURN;
		direct = t - h;
		around = (t > h) ? direct - COUNTS_PER_TURN : direct + COUNTS_PER_TURN;
		// tie goes to the direct path
		err = (((direct < 0) ? -direct : direct) <= ((around < 0) ? -around : around)) ?
			direct : around;
		if (c.rearm) guard_armed = 1'b1;
		r.cleared = (err > -2 && err < 2 && c.req && guard_armed);
		if (r.cleared) begin
			integ_acc   = 0;
			guard_armed = 1'b0;
		end
		rate = (rate_q == 0) ? 1 : longint'(rate_q);
		p = longint'(err) * longint'(kp_q);
		integ_acc += longint'(err) * longint'(ki_q) / rate;
		if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
		if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
		d = (longint'(err) - longint'(err_hist[hist_ptr])) * longint'(kd_q) / rate;
		err_hist[hist_ptr] = err;
		hist_ptr = (hist_ptr + 1) % HIST_DEPTH_DEF;
		resp = longint'(hover_q) + (p + integ_acc + d) / SUM_SCALE;
		r.clamped = 1'b1;
		if (resp > longint'(dmax_q))
			r.duty = dmax_q;
		else if (resp < longint'(dmin_q))
			r.duty = dmin_q;
		else begin
			r.duty    = DUTY_W'(resp);
			r.clamped = 1'b0;
		end
		r.yaw_err = ERR_W'(err);
		return r;
	endfunction

	function automatic yaw_cmd_t make_cmd(int h, int t, bit req, bit rearm);
		yaw_cmd_t c;
		c.heading = HEAD_W'(h);
		c.tdeg    = HEAD_W'(t);
		c.req     = req;
		c.rearm   = rearm;
		return c;
	endfunction

	function automatic yaw_cmd_t rand_cmd();
		yaw_cmd_t c;
		int       sel, tc;
		sel = $urandom_range(99);
		c.tdeg = (sel < 5) ? HEAD_W'($urandom_range(511, 360)) : HEAD_W'($urandom_range(359));
		tc = int'(c.tdeg) * COUNTS_PER_TURN / DEGREES_PER_TURN % COUNTS_PER_TURN;
		// about a third land within one count of the target so the clear path gets hit
		if (sel >= 5 && sel < 38)
			c.heading = HEAD_W'((tc + COUNTS_PER_TURN - 1 + int'($urandom_range(2)))
				% COUNTS_PER_TURN);
		else if ($urandom_range(99) < 5)
			c.heading = HEAD_W'($urandom_range(511, 448));
		else
			c.heading = HEAD_W'($urandom_range(447));
		c.req   = ($urandom_range(99) < 40);
		c.rearm = ($urandom_range(99) < 15);
		return c;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_KP:    kp_q    = val;
			REG_KI:    ki_q    = val;
			REG_KD:    kd_q    = val;
			REG_RATE:  rate_q  = val;
			REG_HOVER: hover_q = val[DUTY_W-1:0];
			REG_DMAX:  dmax_q  = val[DUTY_W-1:0];
			REG_DMIN:  dmin_q  = val[DUTY_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic shuffle_regs();
		int lo;
		lo = $urandom_range(60);
		write_reg(REG_KP, CFG_DATA_W'($urandom_range(1023)));
		write_reg(REG_KI, CFG_DATA_W'($urandom_range(1023)));
		write_reg(REG_KD, CFG_DATA_W'($urandom_range(1023)));
		write_reg(REG_RATE, CFG_DATA_W'($urandom_range(1023)));
		write_reg(REG_HOVER, CFG_DATA_W'($urandom_range(100)));
		write_reg(REG_DMIN, CFG_DATA_W'(lo));
		write_reg(REG_DMAX, CFG_DATA_W'($urandom_range(100, lo)));
	endtask

	task automatic queue_random(int n);
		@(negedge clk);
		repeat (n) cmd_backlog.push_back(rand_cmd());
	endtask

	task automatic drain();
		while (cmd_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				due_results.push_back(yaw_pid_step(yaw_cmd_t'(s_axis_tdata[CMD_W-1:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= 9)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= TDATA_W'(cmd_backlog.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				mon_got = yaw_res_t'(m_axis_tdata[RES_W-1:0]);
				if (due_results.size() == 0) begin
					if (mismatches < 10)
						$display("beat %0d: result with nothing expected (duty %0d err %0d)",
							beats_seen, mon_got.duty, $signed(mon_got.yaw_err));
					mismatches++;
				end else begin
					mon_want = due_results.pop_front();
					if (mon_got.duty !== mon_want.duty || mon_got.yaw_err !== mon_want.yaw_err ||
						mon_got.clamped !== mon_want.clamped ||
						mon_got.cleared !== mon_want.cleared) begin
						if (mismatches < 10)
							$display({"beat %0d: expected duty %0d err %0d clamped %0b cleared %0b,",
								" got duty %0d err %0d clamped %0b cleared %0b"}, beats_seen,
								mon_want.duty, $signed(mon_want.yaw_err), mon_want.clamped,
								mon_want.cleared, mon_got.duty, $signed(mon_got.yaw_err),
								mon_got.clamped, mon_got.cleared);
						mismatches++;
					end
				end
				beats_seen++;
			end
			m_axis_tready <= !(hold_on && !hold_done) && (no_gaps || $urandom_range(99) >= 9);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_on && !hold_done) begin
			if (hold_count == HOLD_CYCLES)
				hold_done <= 1'b1;
			else
				hold_count <= hold_count + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("yaw_pid_with_wrap test failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: guard one-shot, ties, wrap of heading and target
		@(negedge clk);
		cmd_backlog.push_back(make_cmd(0, 0, 1, 0));
		cmd_backlog.push_back(make_cmd(0, 0, 1, 0));
		cmd_backlog.push_back(make_cmd(1, 0, 1, 1));
		cmd_backlog.push_back(make_cmd(0, 1, 1, 1));
		cmd_backlog.push_back(make_cmd(0, 2, 1, 1));
		cmd_backlog.push_back(make_cmd(2, 0, 1, 1));
		cmd_backlog.push_back(make_cmd(0, 180, 0, 0));
		cmd_backlog.push_back(make_cmd(224, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(447, 359, 0, 0));
		cmd_backlog.push_back(make_cmd(0, 359, 0, 0));
		cmd_backlog.push_back(make_cmd(447, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(448, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(511, 90, 0, 0));
		cmd_backlog.push_back(make_cmd(100, 360, 0, 0));
		cmd_backlog.push_back(make_cmd(0, 511, 0, 0));
		cmd_backlog.push_back(make_cmd(300, 450, 0, 0));
		cmd_backlog.push_back(make_cmd(511, 511, 1, 1));
		cmd_backlog.push_back(make_cmd(0, 90, 0, 0));
		cmd_backlog.push_back(make_cmd(0, 270, 0, 0));
		cmd_backlog.push_back(make_cmd(200, 100, 0, 0));
		cmd_backlog.push_back(make_cmd(0, 180, 1, 1));
		drain();

		// full-scale gains, zero rate, hover written with upper bits set
		write_reg(REG_KP, 10'd1023);
		write_reg(REG_KI, 10'd1023);
		write_reg(REG_KD, 10'd1023);
		write_reg(REG_RATE, 10'd0);
		write_reg(REG_HOVER, 10'h3FF);
		write_reg(REG_DMAX, 10'd100);
		write_reg(REG_DMIN, 10'd0);
		write_reg(REG_SPARE, 10'h2AA);
		queue_random(20);
		drain();

		// crossed clamps
		write_reg(REG_HOVER, 10'd50);
		write_reg(REG_DMAX, 10'd10);
		write_reg(REG_DMIN, 10'd90);
		queue_random(15);
		drain();

		// no gain, slowest rate
		write_reg(REG_KP, 10'd0);
		write_reg(REG_KI, 10'd0);
		write_reg(REG_KD, 10'd0);
		write_reg(REG_RATE, 10'h3FF);
		write_reg(REG_HOVER, 10'd0);
		write_reg(REG_DMAX, 10'h3FF);
		write_reg(REG_DMIN, 10'h380);
		queue_random(15);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			shuffle_regs();
			no_gaps = (ph == 2);
			@(negedge clk);
			hold_on = (ph == 4);
			queue_random(200);
			drain();
		end
		no_gaps = 1'b0;

		// drive the integral into saturation, then back off
		write_reg(REG_KI, 10'd1023);
		write_reg(REG_RATE, 10'd1);
		write_reg(REG_KP, CFG_DATA_W'($urandom_range(1023)));
		write_reg(REG_KD, CFG_DATA_W'($urandom_range(1023)));
		write_reg(REG_HOVER, 10'd50);
		write_reg(REG_DMAX, 10'd100);
		write_reg(REG_DMIN, 10'd0);
		sat_up = $urandom_range(1);
		@(negedge clk);
		cmd_backlog.push_back(make_cmd(0, 0, 1, 1));
		repeat (SAT_ITEMS)
			cmd_backlog.push_back(sat_up ? make_cmd(0, 180, 0, 0) : make_cmd(224, 0, 0, 0));
		repeat (20) cmd_backlog.push_back(rand_cmd());
		cmd_backlog.push_back(make_cmd(5, 4, 1, 1));
		repeat (10) cmd_backlog.push_back(rand_cmd());
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("yaw_pid_with_wrap test passed");
		end else begin
			$display("yaw_pid_with_wrap test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/yawpid_pkg.sv
sv/yawpid_ucode.sv
sv/yawpid_div.sv
sv/yawpid_dp.sv
sv/yaw_pid_with_wrap.sv
bench/tb.sv
